>>> rtl/kernel_weighted_cdf_estimate_macros.svh
// Assertion macros for the kernel-weighted CDF estimator.
// Included by the top level; no other dependencies.
`ifndef KERNEL_WEIGHTED_CDF_ESTIMATE_MACROS_SVH
`define KERNEL_WEIGHTED_CDF_ESTIMATE_MACROS_SVH

// Check that a condition holds at every clock edge out of reset
`define KWCE_ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error("kwce assertion failed");

// Check that a trigger implies a condition in the same cycle
`define KWCE_ASSERT_IMP(label, clk, rstn, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (trig) |-> (cond)) \
        else $error("kwce assertion failed");

// Check that a trigger implies a condition in the next cycle
`define KWCE_ASSERT_NEXT(label, clk, rstn, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (trig) |=> (cond)) \
        else $error("kwce assertion failed");

`endif

>>> rtl/kwce_pkg.sv
// Shared types and constants for the kernel-weighted CDF estimator.
// No dependencies; imported by every module of the block.
package kwce_pkg;

    // Accumulator width and saturation limit
    localparam int SUM_W = 30;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Output ratio is Q1.16
    localparam int CDF_FRAC = 16;
    localparam int CDF_W    = CDF_FRAC + 1;

    // Kernel codes
    localparam logic [2:0] KSEL_TRI   = 3'd2;
    localparam logic [2:0] KSEL_EPA   = 3'd3;
    localparam logic [2:0] KSEL_BIW   = 3'd4;
    localparam logic [2:0] KSEL_TRW   = 3'd5;
    localparam logic [2:0] KSEL_RESET = KSEL_TRI;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_QUERY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_KERNEL = 2'd1;

    // Multiplier step selection for the polynomial unit
    typedef enum logic [1:0] {
        POLY_NONE = 2'd0,
        POLY_SQ   = 2'd1,
        POLY_S2   = 2'd2,
        POLY_S3   = 2'd3
    } poly_op_t;

    typedef struct packed {
        logic     load_t;
        poly_op_t op;
    } poly_ctrl_t;

    typedef struct packed {
        logic start;
        logic ratio;
    } div_ctrl_t;

endpackage

>>> rtl/kwce_div.sv
// Shared radix-2 restoring divider, one quotient bit per cycle.
// Depends on kwce_pkg for the control struct and ratio step count.
module kwce_div #(
    parameter int FRAC_BITS = 16,
    parameter int QW        = 17
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  kwce_pkg::div_ctrl_t ctrl,
    input  logic [31:0]        dividend,
    input  logic [31:0]        divisor,
    output logic               done,
    output logic [QW-1:0]      quotient
);
    import kwce_pkg::*;

    localparam int CW = $clog2(QW);
    localparam logic [CW-1:0] T_LAST = CW'(FRAC_BITS);
    localparam logic [CW-1:0] R_LAST = CW'(CDF_FRAC);

    logic [32:0]   rem_reg, rem_next;
    logic [31:0]   dsr_reg;
    logic [QW-1:0] quo_reg, quo_next;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, first_reg, done_reg;
    logic [32:0]   shifted;
    logic          fits;

    // One trial subtraction; the first step takes the dividend unshifted
    always_comb begin
        shifted  = first_reg ? rem_reg : {rem_reg[31:0], 1'b0};
        fits     = shifted >= {1'b0, dsr_reg};
        rem_next = fits ? shifted - {1'b0, dsr_reg} : shifted;
        quo_next = {quo_reg[QW-2:0], fits};
    end

    // Control: step counter, busy and done pulse
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            first_reg <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (ctrl.start) begin
                busy_reg  <= 1'b1;
                first_reg <= 1'b1;
                cnt_reg   <= ctrl.ratio ? R_LAST : T_LAST;
            end else if (busy_reg) begin
                first_reg <= 1'b0;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // Datapath: remainder, divisor and quotient
    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            rem_reg <= {1'b0, dividend};
            dsr_reg <= divisor;
            quo_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/kwce_poly.sv
// Kernel polynomial unit: one shared multiplier forms t*t, s*s and s2*s
// in turn, and the weight is selected from the stored terms.
// Depends on kwce_pkg for kernel codes and the control struct.
module kwce_poly #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  aclk,
    input  kwce_pkg::poly_ctrl_t  ctrl,
    input  logic [FRAC_BITS:0]    t_in,
    input  logic [2:0]            ksel,
    output logic [FRAC_BITS+1:0]  weight
);
    import kwce_pkg::*;

    localparam int F  = FRAC_BITS;
    localparam int VW = F + 1;
    localparam int WW = F + 2;
    localparam logic [VW-1:0] ONE = VW'(1) << F;

    logic [VW-1:0]   t_reg, s_reg, s2_reg, s3_reg;
    logic [VW-1:0]   op_a, op_b;
    logic [2*VW-1:0] prod;
    logic [VW-1:0]   prod_hi;

    // Pick the operands of the shared multiplier
    always_comb begin
        unique case (ctrl.op)
            POLY_SQ: begin
                op_a = t_reg;
                op_b = t_reg;
            end
            POLY_S2: begin
                op_a = s_reg;
                op_b = s_reg;
            end
            POLY_S3: begin
                op_a = s2_reg;
                op_b = s_reg;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
        prod    = op_a * op_b;
        prod_hi = prod[2*F:F];
    end

    // Hold the terms of the polynomial
    always_ff @(posedge aclk) begin
        if (ctrl.load_t) begin
            t_reg <= t_in;
        end
        unique case (ctrl.op)
            POLY_SQ: s_reg  <= ONE - prod_hi;
            POLY_S2: s2_reg <= prod_hi;
            POLY_S3: s3_reg <= prod_hi;
            default: ;
        endcase
    end

    // Constant scaling by shift and add
    logic [WW-1:0]  w_tri;
    logic [F+2:0]   m_epa;
    logic [F+4:0]   m_biw;
    logic [F+6:0]   m_trw;

    always_comb begin
        w_tri = {ONE - t_reg, 1'b0};
        m_epa = {2'b00, s_reg} + {1'b0, s_reg, 1'b0};
        m_biw = {s2_reg, 4'b0000} - {4'b0000, s2_reg};
        m_trw = {1'b0, s3_reg, 5'b00000} + {5'b00000, s3_reg, 1'b0}
              + {6'b000000, s3_reg};
        case (ksel)
            KSEL_TRI: weight = w_tri;
            KSEL_EPA: weight = m_epa[F+2:1];
            KSEL_BIW: weight = m_biw[F+4:3];
            KSEL_TRW: weight = m_trw[F+5:4];
            default:  weight = '0;
        endcase
    end

endmodule

>>> rtl/kernel_weighted_cdf_estimate.sv
// Top level of the kernel-weighted CDF estimator: sequencer, accumulators,
// configuration registers and stream ports. Uses kwce_pkg, kwce_div,
// kwce_poly and the assertion macros header.

// Each input item is one sample (distance, bandwidth, response, last flag).
// The block forms t = distance/bandwidth in the shared radix-2 divider, runs
// three products through one shared multiplier for the kernel polynomial, and
// adds the weight into saturating total and hit sums. A nonzero-weight item
// passes the divider at one quotient bit a cycle, the three multiplier steps
// and the accumulate step; a zero-weight item (zero bandwidth, distance above
// bandwidth, unknown kernel code) goes straight to the accumulate step. A last
// item then forms the hits/total ratio on the same divider unless the total is
// zero, then waits for the result register to be free. s_tready is low while
// an item is at work; a finished result may wait in the output register meanwhile.
// Configuration writes are taken at any time and must only be made idle.
module kernel_weighted_cdf_estimate #(
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input item stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // [31:0] distance, [63:32] bandwidth, [95:64] response
    input  logic        s_tlast,   // last_sample
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [16:0] cdf_value, [23:17] zero
    output logic        m_tuser,   // no_weight
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [kwce_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0] cfg_data
);
    import kwce_pkg::*;

    `include "kernel_weighted_cdf_estimate_macros.svh"

    localparam int F  = FRAC_BITS;
    localparam int WW = F + 2;
    localparam int QW = (F + 1 > CDF_W) ? F + 1 : CDF_W;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_TDIV   = 9'b000000010,
        S_MSQ    = 9'b000000100,
        S_MS2    = 9'b000001000,
        S_MS3    = 9'b000010000,
        S_ACC    = 9'b000100000,
        S_RSTART = 9'b001000000,
        S_RDIV   = 9'b010000000,
        S_EMIT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0]      query_reg;
    logic [2:0]       ksel_reg;
    logic [SUM_W-1:0] hits_reg, total_reg;
    logic [SUM_W-1:0] hits_next, total_next;
    logic             hit_reg, last_reg, wz_reg;
    logic [CDF_W-1:0] cdf_reg;
    logic             nw_reg;
    logic             m_tvalid_reg;
    logic [CDF_W-1:0] m_cdf_reg;
    logic             m_nw_reg;

    logic [31:0] in_dist, in_bw, in_resp;
    logic        in_accept, kcode_ok, w_ok, out_free;

    div_ctrl_t   dctl;
    logic [31:0] div_a, div_b;
    logic        div_done;
    logic [QW-1:0] div_q;

    poly_ctrl_t    pctl;
    logic [WW-1:0] weight;
    logic [WW-1:0] w_eff;
    logic [SUM_W:0] tot_sum, hit_sum;

    // Unpack the input item
    assign in_dist   = s_tdata[31:0];
    assign in_bw     = s_tdata[63:32];
    assign in_resp   = s_tdata[95:64];
    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    // Decide up front whether the sample can carry any weight
    always_comb begin
        case (ksel_reg) inside
            KSEL_TRI, KSEL_EPA, KSEL_BIW, KSEL_TRW: kcode_ok = 1'b1;
            default:                                kcode_ok = 1'b0;
        endcase
        w_ok = kcode_ok && (in_bw != '0) && (in_dist <= in_bw);
    end

    // Configuration registers
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            query_reg <= '0;
            ksel_reg  <= KSEL_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_IDX_QUERY:  query_reg <= cfg_data;
                CFG_IDX_KERNEL: ksel_reg  <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Shared divider: t on accepting a weighted item, hits/total at the end of a set
    always_comb begin
        dctl.start = (in_accept && w_ok) || (state_reg == S_RSTART);
        dctl.ratio = (state_reg == S_RSTART);
        if (state_reg == S_RSTART) begin
            div_a = {{(32-SUM_W){1'b0}}, hits_reg};
            div_b = {{(32-SUM_W){1'b0}}, total_reg};
        end else begin
            div_a = in_dist;
            div_b = in_bw;
        end
    end

    kwce_div #(
        .FRAC_BITS (F),
        .QW        (QW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (dctl),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    // Polynomial unit steps follow the sequencer
    always_comb begin
        pctl.load_t = (state_reg == S_TDIV) && div_done;
        unique case (state_reg)
            S_MSQ:   pctl.op = POLY_SQ;
            S_MS2:   pctl.op = POLY_S2;
            S_MS3:   pctl.op = POLY_S3;
            default: pctl.op = POLY_NONE;
        endcase
    end

    kwce_poly #(
        .FRAC_BITS (F)
    ) u_poly (
        .aclk   (aclk),
        .ctrl   (pctl),
        .t_in   (div_q[F:0]),
        .ksel   (ksel_reg),
        .weight (weight)
    );

    // Saturating accumulation of the weight
    always_comb begin
        w_eff      = wz_reg ? '0 : weight;
        tot_sum    = {1'b0, total_reg} + (SUM_W+1)'(w_eff);
        hit_sum    = {1'b0, hits_reg} + (SUM_W+1)'(w_eff);
        total_next = tot_sum[SUM_W] ? SUM_MAX : tot_sum[SUM_W-1:0];
        if (hit_reg) begin
            hits_next = hit_sum[SUM_W] ? SUM_MAX : hit_sum[SUM_W-1:0];
        end else begin
            hits_next = hits_reg;
        end
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    state_next = w_ok ? S_TDIV : S_ACC;
                end
            end
            S_TDIV: begin
                if (div_done) begin
                    state_next = S_MSQ;
                end
            end
            S_MSQ: state_next = S_MS2;
            S_MS2: state_next = S_MS3;
            S_MS3: state_next = S_ACC;
            S_ACC: begin
                if (!last_reg) begin
                    state_next = S_IDLE;
                end else if (total_next == '0) begin
                    state_next = S_EMIT;
                end else begin
                    state_next = S_RSTART;
                end
            end
            S_RSTART: state_next = S_RDIV;
            S_RDIV: begin
                if (div_done) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Latch the per-item flags
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            hit_reg  <= $signed(in_resp) <= $signed(query_reg);
            last_reg <= s_tlast;
            wz_reg   <= !w_ok;
        end
    end

    // Accumulators: add in ACC, clear once the result is handed on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hits_reg  <= '0;
            total_reg <= '0;
        end else if (state_reg == S_ACC) begin
            hits_reg  <= hits_next;
            total_reg <= total_next;
        end else if ((state_reg == S_EMIT) && out_free) begin
            hits_reg  <= '0;
            total_reg <= '0;
        end
    end

    // Hold the ratio until the output register is free
    always_ff @(posedge aclk) begin
        if ((state_reg == S_ACC) && (total_next == '0)) begin
            cdf_reg <= '0;
            nw_reg  <= 1'b1;
        end else if ((state_reg == S_RDIV) && div_done) begin
            cdf_reg <= div_q[CDF_W-1:0];
            nw_reg  <= 1'b0;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if ((state_reg == S_EMIT) && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == S_EMIT) && out_free) begin
            m_cdf_reg <= cdf_reg;
            m_nw_reg  <= nw_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(24-CDF_W){1'b0}}, m_cdf_reg};
    assign m_tuser  = m_nw_reg;

    // Checks
    `KWCE_ASSERT_ALWAYS(a_hits_le_total, aclk, aresetn, hits_reg <= total_reg)
    `KWCE_ASSERT_IMP(a_div_done_in_div, aclk, aresetn, div_done,
        (state_reg == S_TDIV) || (state_reg == S_RDIV))
    `KWCE_ASSERT_IMP(a_no_weight_zero, aclk, aresetn, m_tvalid_reg && m_nw_reg,
        m_cdf_reg == '0)
    `KWCE_ASSERT_NEXT(a_sums_cleared, aclk, aresetn, (state_reg == S_EMIT) && out_free,
        (total_reg == '0) && (hits_reg == '0))

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for kernel_weighted_cdf_estimate: directed table, random sets
// and a long heavy set; each result checked by the in-bench predictor or a typed row.
// Depends on kwce_pkg and the RTL of the block only.
module testbench;
    import kwce_pkg::*;

    localparam int          DIR_ROWS     = 18;
    localparam int          RANDOM_ITEMS = 1000;
    localparam int          SAT_ITEMS    = 400;
    localparam int          SETTLE_CYC   = 50;
    localparam int          WATCHDOG_MAX = 4000;
    localparam logic [63:0] UNIT_Q16     = 64'd65536;
    localparam logic [31:0] LVL_MIN      = 32'h8000_0000;
    localparam logic [31:0] LVL_MAX      = 32'h7FFF_FFFF;
    localparam logic [31:0] LVL_ONE      = 32'h0001_0000;
    localparam logic [31:0] LVL_NEG_LSB  = 32'hFFFF_FFFF;
    // Kernel codes with no kernel behind them
    localparam logic [2:0]  KSEL_UNUSED_0 = 3'd0;
    localparam logic [2:0]  KSEL_UNUSED_6 = 3'd6;
    localparam logic [2:0]  KSEL_UNUSED_7 = 3'd7;

    typedef struct packed {
        logic [CDF_W-1:0] cdf;
        logic             nw;
    } cdf_result_t;

    typedef struct packed {
        logic [2:0]       ksel;
        logic [31:0]      lvl;
        logic [31:0]      distance;
        logic [31:0]      bw;
        logic [31:0]      resp;
        logic             last;
        logic             typed;
        logic [CDF_W-1:0] cdf;
        logic             nw;
    } sample_row_t;

    typedef enum logic [1:0] {RX_OPEN, RX_HOLD, RX_JITTER} rx_mode_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [95:0]          s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [23:0]          m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;

    // Predictor state
    logic [31:0]      query_q;
    logic [2:0]       kernel_q;
    logic [SUM_W-1:0] hit_sum;
    logic [SUM_W-1:0] weight_sum;
    cdf_result_t      cdf_expect_q[$];

    int          mismatch_cnt;
    int          burst_left;
    int          idle_cycles;
    int          rx_left;
    rx_mode_t    rx_mode;
    sample_row_t dir_tab [DIR_ROWS];

    kernel_weighted_cdf_estimate u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Weight of one sample in Q2.16
    function automatic logic [63:0] sample_weight(logic [31:0] distance, logic [31:0] bw,
                                                  logic [2:0] sel);
        logic [63:0] t, s, s2, s3;
        if (bw == 32'd0 || distance > bw)
            return 64'd0;
        t = ({32'd0, distance} << 16) / {32'd0, bw};
        if (t > UNIT_Q16)
            t = UNIT_Q16;
        s  = UNIT_Q16 - ((t * t) >> 16);
        s2 = (s * s) >> 16;
        s3 = (s2 * s) >> 16;
        case (sel)
            KSEL_TRI: return 64'd2 * (UNIT_Q16 - t);
            KSEL_EPA: return (64'd3 * s) >> 1;
            KSEL_BIW: return (64'd15 * s2) >> 3;
            KSEL_TRW: return (64'd35 * s3) >> 4;
            default:  return 64'd0;
        endcase
    endfunction

    function automatic logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] acc, logic [63:0] w);
        logic [63:0] r;
        r = {{(64-SUM_W){1'b0}}, acc} + w;
        return (r > {{(64-SUM_W){1'b0}}, SUM_MAX}) ? SUM_MAX : r[SUM_W-1:0];
    endfunction

    // Fold one accepted sample into the sums; emit the CDF on the last one
    task automatic account_sample(input logic [31:0] distance, input logic [31:0] bw,
                                  input logic [31:0] resp, input logic last,
                                  output logic done, output cdf_result_t res);
        logic [63:0] w;
        logic [63:0] ratio;
        w          = sample_weight(distance, bw, kernel_q);
        weight_sum = sat_sum(weight_sum, w);
        if ($signed(resp) <= $signed(query_q))
            hit_sum = sat_sum(hit_sum, w);
        done = last;
        res  = '0;
        if (last) begin
            if (weight_sum == '0) begin
                res.nw = 1'b1;
            end else begin
                ratio = ({{(64-SUM_W){1'b0}}, hit_sum} << CDF_FRAC) / weight_sum;
                if (ratio > UNIT_Q16)
                    ratio = UNIT_Q16;
                res.cdf = ratio[CDF_W-1:0];
            end
            hit_sum    = '0;
            weight_sum = '0;
        end
    endtask

    // Bursts of random length, random gaps between them
    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            case ($urandom_range(0, 3))
                0:       gap = 0;
                1:       gap = $urandom_range(1, 4);
                2:       gap = $urandom_range(5, 30);
                default: gap = $urandom_range(20, 60);
            endcase
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
    endtask

    // Offer one item and hold it until taken; valid stays up for the caller
    task automatic send_sample(input logic [31:0] distance, input logic [31:0] bw,
                               input logic [31:0] resp, input logic last,
                               input logic typed, input cdf_result_t typed_res);
        logic        done;
        cdf_result_t res;
        s_tdata  <= {resp, bw, distance};
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        account_sample(distance, bw, resp, last, done, res);
        if (done)
            cdf_expect_q.push_back(typed ? typed_res : res);
    endtask

    // Hold the sender until every result is out and the block has gone quiet
    task automatic drain();
        s_tvalid <= 1'b0;
        while (cdf_expect_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_IDX_QUERY)
            query_q = val;
        else if (idx == CFG_IDX_KERNEL)
            kernel_q = val[2:0];
    endtask

    task automatic apply_config(input logic [2:0] ksel, input logic [31:0] lvl);
        drain();
        write_reg(CFG_IDX_QUERY, lvl);
        write_reg(CFG_IDX_KERNEL, {29'd0, ksel});
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [2:0] pick_kernel();
        if ($urandom_range(0, 4) == 0)
            return 3'($urandom_range(0, 7));
        return 3'(KSEL_TRI + $urandom_range(0, 3));
    endfunction

    function automatic logic [31:0] pick_level();
        case ($urandom_range(0, 5))
            0:       return LVL_MIN;
            1:       return LVL_MAX;
            2:       return 32'd0;
            3:       return $urandom;
            default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        endcase
    endfunction

    function automatic logic [31:0] pick_bandwidth();
        case ($urandom_range(0, 9))
            0:             return 32'd0;
            1:             return 32'hFFFF_FFFF;
            2, 3, 4, 5:    return $urandom_range(1, 32'h0004_0000);
            default:       return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_distance(logic [31:0] bw);
        logic [63:0] frac;
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return bw;
            2:       return bw + 32'd1;
            3:       return $urandom;
            4:       return 32'hFFFF_FFFF;
            default: begin
                frac = {32'd0, bw};
                frac = (frac * $urandom_range(0, 65536)) >> 16;
                return frac[31:0];
            end
        endcase
    endfunction

    function automatic logic [31:0] pick_response(logic [31:0] lvl);
        case ($urandom_range(0, 7))
            0:       return lvl;
            1:       return lvl + 32'd1;
            2:       return lvl - 32'd1;
            3:       return LVL_MIN;
            4:       return LVL_MAX;
            5:       return $urandom;
            default: return lvl + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        endcase
    endfunction

    // Receiver: open, held off or jittering, each for a random stretch
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            rx_left = $urandom_range(1, 60);
        end else begin
            rx_left = rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN: m_tready <= 1'b1;
            RX_HOLD: m_tready <= 1'b0;
            default: m_tready <= 1'($urandom_range(0, 1));
        endcase
    end

    // Compare each result item with the oldest expectation
    always @(posedge aclk) begin
        cdf_result_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            if (cdf_expect_q.size() == 0) begin
                $error("unexpected result item: cdf_value %0d, no_weight %0b",
                       m_tdata[CDF_W-1:0], m_tuser);
                mismatch_cnt++;
            end else begin
                exp_res = cdf_expect_q.pop_front();
                if (m_tdata[CDF_W-1:0] !== exp_res.cdf) begin
                    $error("cdf_value: expected %0d, got %0d", exp_res.cdf,
                           m_tdata[CDF_W-1:0]);
                    mismatch_cnt++;
                end
                if (m_tuser !== exp_res.nw) begin
                    $error("no_weight: expected %0b, got %0b", exp_res.nw, m_tuser);
                    mismatch_cnt++;
                end
                if (m_tdata[23:CDF_W] !== '0) begin
                    $error("tdata padding: expected 0, got %0h", m_tdata[23:CDF_W]);
                    mismatch_cnt++;
                end
            end
        end
    end

    // Abort when no channel moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_MAX) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        sample_row_t row;
        cdf_result_t row_res;
        logic [31:0] bw, distance, resp, rnd;
        int          items_sent;
        int          set_cnt;
        int          set_len;

        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        m_tready  <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        query_q      = 32'd0;
        kernel_q     = KSEL_RESET;
        hit_sum      = '0;
        weight_sum   = '0;
        mismatch_cnt = 0;
        burst_left   = 0;
        rx_left      = 0;
        rx_mode      = RX_OPEN;
        items_sent   = 0;
        set_cnt      = 0;

        // ksel, level, distance, bandwidth, response, last, typed, cdf, no_weight
        dir_tab = '{
            // full weight at reset settings, response on the level
            '{KSEL_TRI, 32'd0, 32'd0, 32'd1, 32'd0, 1'b1, 1'b1, 17'd65536, 1'b0},
            // zero bandwidth
            '{KSEL_TRI, 32'd0, 32'd5, 32'd0, 32'd0, 1'b1, 1'b1, 17'd0, 1'b1},
            // distance above bandwidth
            '{KSEL_TRI, 32'd0, 32'd2, 32'd1, 32'd0, 1'b1, 1'b1, 17'd0, 1'b1},
            // t exactly one gives zero weight
            '{KSEL_TRI, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, LVL_MAX, 1'b1, 1'b1,
              17'd0, 1'b1},
            '{KSEL_TRI, 32'd0, 32'd0, 32'hFFFF_FFFF, LVL_MAX, 1'b1, 1'b1, 17'd0, 1'b0},
            '{KSEL_TRI, 32'd0, 32'd0, 32'd1, LVL_MIN, 1'b0, 1'b0, 17'd0, 1'b0},
            '{KSEL_TRI, 32'd0, 32'h8000, 32'h1_0000, 32'd1, 1'b1, 1'b0, 17'd0, 1'b0},
            '{KSEL_EPA, LVL_ONE, 32'h4000, 32'h1_0000, 32'h1_0000, 1'b0, 1'b0,
              17'd0, 1'b0},
            '{KSEL_EPA, LVL_ONE, 32'hC000, 32'h1_0000, 32'h1_0001, 1'b1, 1'b0,
              17'd0, 1'b0},
            '{KSEL_BIW, LVL_MIN, 32'd1, 32'd3, LVL_MIN, 1'b0, 1'b0, 17'd0, 1'b0},
            '{KSEL_BIW, LVL_MIN, 32'h1234, 32'h5678, 32'h8000_0001, 1'b1, 1'b0,
              17'd0, 1'b0},
            '{KSEL_TRW, LVL_MAX, 32'd0, 32'h1_0000, LVL_MAX, 1'b1, 1'b1, 17'd65536, 1'b0},
            '{KSEL_TRW, LVL_MAX, 32'hFFFF, 32'h1_0000, 32'd0, 1'b1, 1'b0, 17'd0, 1'b0},
            // unknown kernel codes weigh nothing
            '{KSEL_UNUSED_0, 32'd0, 32'd0, 32'd1, 32'd0, 1'b1, 1'b1, 17'd0, 1'b1},
            '{KSEL_UNUSED_6, 32'd0, 32'd0, 32'd1, 32'd0, 1'b1, 1'b1, 17'd0, 1'b1},
            '{KSEL_UNUSED_7, 32'd0, 32'd0, 32'd1, 32'd0, 1'b1, 1'b1, 17'd0, 1'b1},
            '{KSEL_TRI, LVL_NEG_LSB, 32'd0, 32'd1, LVL_NEG_LSB, 1'b0, 1'b0, 17'd0, 1'b0},
            '{KSEL_TRI, LVL_NEG_LSB, 32'd0, 32'd1, 32'd0, 1'b1, 1'b0, 17'd0, 1'b0}
        };

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table, reconfiguring only when a row asks for other settings
        for (int i = 0; i < DIR_ROWS; i++) begin
            row = dir_tab[i];
            if (row.ksel != kernel_q || row.lvl != query_q)
                apply_config(row.ksel, row.lvl);
            row_res.cdf = row.cdf;
            row_res.nw  = row.nw;
            pace_sender();
            send_sample(row.distance, row.bw, row.resp, row.last, row.typed, row_res);
        end

        // Random well-formed sets, new settings every few sets
        while (items_sent < RANDOM_ITEMS) begin
            if (set_cnt % 8 == 0)
                apply_config(pick_kernel(), pick_level());
            set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(1, 12);
            for (int j = 0; j < set_len; j++) begin
                bw       = pick_bandwidth();
                distance = pick_distance(bw);
                resp     = pick_response(query_q);
                pace_sender();
                send_sample(distance, bw, resp, j == set_len - 1, 1'b0, '0);
                items_sent++;
            end
            set_cnt++;
        end

        // One long set at full triweight to build large sums
        apply_config(KSEL_TRW, 32'd0);
        for (int j = 0; j < SAT_ITEMS; j++) begin
            rnd  = $urandom;
            resp = {($urandom_range(0, 15) != 0), rnd[30:0]};
            pace_sender();
            send_sample(32'd0, $urandom | 32'd1, resp, j == SAT_ITEMS - 1, 1'b0, '0);
        end

        // Wait out the last results, then settle
        s_tvalid <= 1'b0;
        while (cdf_expect_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
        if (mismatch_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
